### rtl/periodic_task_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Periodic task scheduler assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared constants, register codes, sequencer states and step flags.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Tasks described by the configuration words (one byte each).
  localparam int CFG_TASKS = 8;
  localparam int TASK_W    = 3;
  localparam int RUN_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 64;
  localparam int CNT_W     = 4;
  localparam int MISS_W    = 16;
  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [MISS_W-1:0] MISS_MAX = '1;
  localparam logic [RUN_W-1:0]  RUN_IDLE = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUNTIMES = 8'd3;

  // Register reset values
  localparam logic             POLICY_RST   = 1'b0;
  localparam logic [CNT_W-1:0] COUNT_RST    = 4'd2;
  localparam logic [WORD_W-1:0] PERIODS_RST  = 64'h0000_0000_0000_0705;
  localparam logic [WORD_W-1:0] RUNTIMES_RST = 64'h0000_0000_0000_0402;

  // Policy codes
  localparam logic POLICY_RMS = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_CHARGE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  // Per-task outcome of one scan step
  typedef struct packed {
    logic release_now;
    logic miss;
    logic active;
    logic take;
  } step_flags_t;

endpackage

### rtl/pts_task_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task step unit
// Release check, counter reload and priority compare for one task per cycle.
// ----------------------------------------------------------------------------
module pts_task_step #(
  parameter int COUNT_WIDTH = 8,
  parameter int KEY_W       = 8
) (
  input  logic                        policy,
  input  logic [pts_pkg::BYTE_W-1:0]  period_byte,
  input  logic [pts_pkg::BYTE_W-1:0]  runtime_byte,
  input  logic                        active,
  input  logic [COUNT_WIDTH-1:0]      remaining,
  input  logic [COUNT_WIDTH-1:0]      countdown,
  input  logic                        best_vld,
  input  logic [KEY_W-1:0]            best_key,
  output pts_pkg::step_flags_t        flags,
  output logic [COUNT_WIDTH-1:0]      remaining_upd,
  output logic [COUNT_WIDTH-1:0]      countdown_nxt,
  output logic [KEY_W-1:0]            key
);

  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam int SAT_W = (COUNT_WIDTH > pts_pkg::BYTE_W) ? COUNT_WIDTH : pts_pkg::BYTE_W;

  logic [COUNT_WIDTH-1:0] period_sat;
  logic [COUNT_WIDTH-1:0] runtime_sat;
  logic [COUNT_WIDTH-1:0] countdown_upd;
  logic                   rel;

  // Load bytes into counters, saturating when the counter is narrower
  assign period_sat  = (SAT_W'(period_byte) > SAT_W'(CMAX)) ? CMAX
                                                            : COUNT_WIDTH'(period_byte);
  assign runtime_sat = (SAT_W'(runtime_byte) > SAT_W'(CMAX)) ? CMAX
                                                             : COUNT_WIDTH'(runtime_byte);

  assign rel           = (period_byte != '0) && (countdown == '0);
  assign remaining_upd = rel ? runtime_sat : remaining;
  assign countdown_upd = rel ? period_sat : countdown;

  // EDF keys on time left to the deadline, RMS on the period
  assign key = (policy == pts_pkg::POLICY_EDF) ? KEY_W'(countdown_upd) : KEY_W'(period_byte);

  // Count down after the compare has seen the post-release value
  assign countdown_nxt = (countdown_upd != '0) ? countdown_upd - 1'b1 : countdown_upd;

  assign flags.release_now = rel;
  assign flags.miss        = rel && (remaining != '0);
  assign flags.active      = active || rel;
  assign flags.take        = (active || rel) && (!best_vld || (key < best_key));

endmodule

### rtl/periodic_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler
// One transaction per scheduler tick: release, pick and charge one task.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction per tick; in_clear = 1 restarts time and clears
//            all task state (configuration registers are kept).
//   out_*  : one result transaction per input transaction, in order.
//   cfg_*  : register writes (policy, task count, periods, run times);
//            always ready, write only while the block is idle.
// Timing:
//   A tick walks the n tasks in use through one shared release/compare unit,
//   one task per cycle, then charges the chosen task and emits the result.
//   The result becomes valid in the same cycle as in_ready returns; a clear
//   skips the scan and charge steps and goes straight to the emit step.
// Reset:
//   Synchronous, active low. Registers return to their defaults (two tasks,
//   rate monotonic), all task state is zero, time restarts at zero.
// Stall:
//   A result held by a low out_ready stays on out_*; the next tick is
//   accepted, but it waits after its charge step until the result is taken.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_macros.svh"

module periodic_task_scheduler #(
  parameter int TASKS       = 8,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pts_pkg::WORD_W-1:0]         cfg_data,
  // tick input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_clear,
  // result
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pts_pkg::RUN_W-1:0]          out_running_task,
  output logic                               out_completed,
  output logic [pts_pkg::CFG_TASKS-1:0]      out_miss_mask,
  output logic [pts_pkg::MISS_W-1:0]         out_miss_total,
  output logic [pts_pkg::TIME_W-1:0]         out_tick_time
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int KEY_W = (COUNT_WIDTH > pts_pkg::BYTE_W) ? COUNT_WIDTH : pts_pkg::BYTE_W;
  localparam int NLIM  = (TASKS < pts_pkg::CFG_TASKS) ? TASKS : pts_pkg::CFG_TASKS;

  // Configuration registers
  logic                         policy_r;
  logic [pts_pkg::CNT_W-1:0]    task_count_r;
  logic [pts_pkg::WORD_W-1:0]   periods_r;
  logic [pts_pkg::WORD_W-1:0]   runtimes_r;

  // Task state
  logic                         active_r [TASKS];
  logic [COUNT_WIDTH-1:0]       rem_r    [TASKS];
  logic [COUNT_WIDTH-1:0]       cd_r     [TASKS];
  logic [pts_pkg::MISS_W-1:0]   miss_r;
  logic [pts_pkg::TIME_W-1:0]   time_r;

  // Sequencer
  pts_pkg::state_t              state_r;
  logic [pts_pkg::TASK_W-1:0]   k_r;
  logic                         best_vld_r;
  logic [pts_pkg::TASK_W-1:0]   best_r;
  logic [KEY_W-1:0]             best_key_r;
  logic [COUNT_WIDTH-1:0]       best_rem_r;
  logic [pts_pkg::CFG_TASKS-1:0] mask_r;
  logic [pts_pkg::TIME_W-1:0]   res_time_r;
  logic                         res_done_r;

  // Output stage
  logic                         out_valid_r;
  logic [pts_pkg::RUN_W-1:0]    out_task_r;
  logic                         out_done_r;
  logic [pts_pkg::CFG_TASKS-1:0] out_mask_r;
  logic [pts_pkg::MISS_W-1:0]   out_miss_r;
  logic [pts_pkg::TIME_W-1:0]   out_time_r;

  logic [pts_pkg::CNT_W-1:0]    n_eff;
  logic [IDX_W-1:0]             scan_idx;
  logic [IDX_W-1:0]             best_idx;
  logic                         scan_last;
  logic                         in_fire;
  logic                         out_load;
  logic [COUNT_WIDTH-1:0]       rem_chg;
  logic                         chg_done;
  logic                         out_is_idle;

  pts_pkg::step_flags_t         st_flags;
  logic [COUNT_WIDTH-1:0]       st_rem;
  logic [COUNT_WIDTH-1:0]       st_cd;
  logic [KEY_W-1:0]             st_key;

  assign n_eff     = (task_count_r > pts_pkg::CNT_W'(NLIM)) ? pts_pkg::CNT_W'(NLIM)
                                                            : task_count_r;
  assign scan_idx  = IDX_W'(k_r);
  assign best_idx  = IDX_W'(best_r);
  assign scan_last = (pts_pkg::CNT_W'(k_r) == (n_eff - 1'b1));
  assign in_ready  = (state_r == pts_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == pts_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  assign rem_chg  = (best_rem_r != '0) ? best_rem_r - 1'b1 : best_rem_r;
  assign chg_done = best_vld_r && (rem_chg == '0);

  pts_task_step #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .KEY_W       (KEY_W)
  ) u_step (
    .policy        (policy_r),
    .period_byte   (periods_r[pts_pkg::BYTE_W*k_r +: pts_pkg::BYTE_W]),
    .runtime_byte  (runtimes_r[pts_pkg::BYTE_W*k_r +: pts_pkg::BYTE_W]),
    .active        (active_r[scan_idx]),
    .remaining     (rem_r[scan_idx]),
    .countdown     (cd_r[scan_idx]),
    .best_vld      (best_vld_r),
    .best_key      (best_key_r),
    .flags         (st_flags),
    .remaining_upd (st_rem),
    .countdown_nxt (st_cd),
    .key           (st_key)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= pts_pkg::POLICY_RST;
      task_count_r <= pts_pkg::COUNT_RST;
      periods_r    <= pts_pkg::PERIODS_RST;
      runtimes_r   <= pts_pkg::RUNTIMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pts_pkg::REG_POLICY:   policy_r     <= cfg_data[0];
        pts_pkg::REG_COUNT:    task_count_r <= cfg_data[pts_pkg::CNT_W-1:0];
        pts_pkg::REG_PERIODS:  periods_r    <= cfg_data;
        pts_pkg::REG_RUNTIMES: runtimes_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and task state
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_clear)) begin
      for (int i = 0; i < TASKS; i++) begin
        active_r[i] <= 1'b0;
        rem_r[i]    <= '0;
        cd_r[i]     <= '0;
      end
      miss_r <= '0;
      time_r <= '0;
    end else begin
      if (state_r == pts_pkg::ST_SCAN) begin
        active_r[scan_idx] <= st_flags.active;
        rem_r[scan_idx]    <= st_rem;
        cd_r[scan_idx]     <= st_cd;
        if (st_flags.miss && (miss_r != pts_pkg::MISS_MAX)) begin
          miss_r <= miss_r + 1'b1;
        end
      end
      if (state_r == pts_pkg::ST_CHARGE) begin
        if (best_vld_r) begin
          rem_r[best_idx] <= rem_chg;
          if (chg_done) begin
            active_r[best_idx] <= 1'b0;
          end
        end
        time_r <= time_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pts_pkg::ST_IDLE;
      k_r        <= '0;
      best_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        pts_pkg::ST_IDLE: begin
          if (in_fire) begin
            k_r        <= '0;
            best_vld_r <= 1'b0;
            mask_r     <= '0;
            res_done_r <= 1'b0;
            res_time_r <= in_clear ? '0 : time_r;
            if (in_clear) begin
              state_r <= pts_pkg::ST_EMIT;
            end else if (n_eff == '0) begin
              state_r <= pts_pkg::ST_CHARGE;
            end else begin
              state_r <= pts_pkg::ST_SCAN;
            end
          end
        end
        pts_pkg::ST_SCAN: begin
          if (st_flags.miss) begin
            mask_r[k_r] <= 1'b1;
          end
          if (st_flags.take) begin
            best_vld_r <= 1'b1;
            best_r     <= k_r;
            best_key_r <= st_key;
            best_rem_r <= st_rem;
          end
          k_r <= k_r + 1'b1;
          if (scan_last) begin
            state_r <= pts_pkg::ST_CHARGE;
          end
        end
        pts_pkg::ST_CHARGE: begin
          res_done_r <= chg_done;
          state_r    <= pts_pkg::ST_EMIT;
        end
        pts_pkg::ST_EMIT: begin
          if (out_load) begin
            state_r <= pts_pkg::ST_IDLE;
          end
        end
        default: state_r <= pts_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_task_r <= best_vld_r ? pts_pkg::RUN_W'(best_r) + 1'b1 : pts_pkg::RUN_IDLE;
      out_done_r <= res_done_r;
      out_mask_r <= mask_r;
      out_miss_r <= miss_r;
      out_time_r <= res_time_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_running_task = out_task_r;
  assign out_completed    = out_done_r;
  assign out_miss_mask    = out_mask_r;
  assign out_miss_total   = out_miss_r;
  assign out_tick_time    = out_time_r;

  assign out_is_idle = (out_running_task == pts_pkg::RUN_IDLE);

  `PTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `PTS_ASSERT_NOW(a_idle_not_done, out_valid && out_is_idle, !out_completed, "done without task")
  `PTS_ASSERT_NOW(a_miss_counted, out_valid && (|out_miss_mask), |out_miss_total, "miss not counted")

endmodule
